// ===== rtl/ltsolve_pkg.sv =====
// shared widths, field layout and controller/datapath command types
// for the lower triangular solver; no dependencies
`timescale 1ns / 1ps

package ltsolve_pkg;

	localparam int IDX_W      = 4;
	localparam int DATA_W     = 32;
	localparam int SUM_W      = 64;
	localparam int SIZE_W     = 5;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 2;
	localparam int DIV_STEPS  = 64;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int CFG_RESET  = 1;

	typedef struct packed {
		logic capture;
		logic mul_en;
		logic acc_en;
		logic num_en;
		logic div_start;
		logic fin_en;
		logic last;
	} ltsolve_cmd_t;

	typedef struct packed {
		logic div_done;
		logic coef_zero;
		logic out_free;
	} ltsolve_stat_t;

endpackage

// ===== rtl/ltsolve_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ltsolve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ltsolve_div.sv =====
// iterative unsigned divider, 64-bit dividend by 32-bit divisor,
// one quotient bit per cycle; uses ltsolve_pkg
`timescale 1ns / 1ps

module ltsolve_div import ltsolve_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quotient
);

	logic [SUM_W-1:0]     quo_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic                 ge;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ltsolve_dp.sv =====
// datapath: item registers, solution ram, multiply-accumulate, numerator,
// divider and output register; uses ltsolve_pkg, ltsolve_ram, ltsolve_div
`timescale 1ns / 1ps

module ltsolve_dp import ltsolve_pkg::*; #(
	parameter int MAX_SIZE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltsolve_cmd_t         cmd,
	output ltsolve_stat_t        stat,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	output logic                 m_tlast
);

	localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	logic [IDX_W-1:0]         in_row;
	logic [IDX_W-1:0]         in_col;
	logic [DATA_W-1:0]        in_coef;
	logic [DATA_W-1:0]        in_rhs;
	logic [IDX_W-1:0]         row_q;
	logic signed [DATA_W-1:0] coef_q;
	logic signed [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0]        rd_data;
	logic signed [SUM_W-1:0]  prod_s1;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  num_q;
	logic                     neg_q;
	logic [SUM_W:0]           add_ext;
	logic [SUM_W-1:0]         add_sat;
	logic [SUM_W-1:0]         rhs_scaled;
	logic [SUM_W:0]           sub_ext;
	logic [SUM_W-1:0]         sub_sat;
	logic [SUM_W-1:0]         num_mag;
	logic [DATA_W-1:0]        coef_mag;
	logic                     div_done;
	logic [SUM_W-1:0]         quo;
	logic                     ovf;
	logic [DATA_W-1:0]        qval;
	logic [DATA_W-1:0]        res_val;
	logic                     out_valid_q;
	logic                     out_free;

	assign in_row  = s_tdata[3:0];
	assign in_col  = s_tdata[7:4];
	assign in_coef = s_tdata[39:8];
	assign in_rhs  = s_tdata[71:40];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q  <= in_row;
			coef_q <= in_coef;
			rhs_q  <= in_rhs;
		end
	end

	ltsolve_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_SIZE)
	) u_store (
		.clk   (clk),
		.we    (cmd.fin_en),
		.waddr (AW'(row_q)),
		.wdata (res_val),
		.re    (cmd.capture),
		.raddr (AW'(in_col)),
		.rdata (rd_data)
	);

	// multiply-accumulate with 64-bit saturation
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= coef_q * $signed(rd_data);
		end
	end

	assign add_ext = {sum_q[SUM_W-1], sum_q} + {prod_s1[SUM_W-1], prod_s1};
	always_comb begin
		if (add_ext[SUM_W] != add_ext[SUM_W-1]) begin
			add_sat = add_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			add_sat = add_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.fin_en) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= add_sat;
		end
	end

	// numerator rhs * 2^16 - sum, saturated
	assign rhs_scaled = {{(SUM_W-DATA_W-16){rhs_q[DATA_W-1]}}, rhs_q, 16'h0000};
	assign sub_ext    = {rhs_scaled[SUM_W-1], rhs_scaled} - {sum_q[SUM_W-1], sum_q};
	always_comb begin
		if (sub_ext[SUM_W] != sub_ext[SUM_W-1]) begin
			sub_sat = sub_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sub_sat = sub_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.num_en) begin
			num_q <= sub_sat;
		end
		if (cmd.div_start) begin
			neg_q <= num_q[SUM_W-1] ^ coef_q[DATA_W-1];
		end
	end

	assign num_mag  = num_q[SUM_W-1] ? (SUM_W'(0) - num_q) : num_q;
	assign coef_mag = coef_q[DATA_W-1] ? (DATA_W'(0) - coef_q) : coef_q;

	ltsolve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_mag),
		.divisor  (coef_mag),
		.done     (div_done),
		.quotient (quo)
	);

	// signed saturation of the quotient magnitude
	always_comb begin
		if (!neg_q) begin
			ovf  = (quo[SUM_W-1:DATA_W-1] != '0);
			qval = ovf ? {1'b0, {(DATA_W-1){1'b1}}} : quo[DATA_W-1:0];
		end else begin
			ovf  = (quo[SUM_W-1:DATA_W] != '0)
				|| (quo[DATA_W-1] && (quo[DATA_W-2:0] != '0));
			qval = ovf ? {1'b1, {(DATA_W-1){1'b0}}} : (DATA_W'(0) - quo[DATA_W-1:0]);
		end
	end

	assign res_val = stat.coef_zero ? '0 : qval;

	// output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			m_tdata <= {{(M_TDATA_W-DATA_W-IDX_W){1'b0}}, res_val, row_q};
			m_tuser <= {(!stat.coef_zero) & ovf, stat.coef_zero};
			m_tlast <= cmd.last;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign stat.div_done  = div_done;
	assign stat.coef_zero = (coef_q == '0);
	assign stat.out_free  = out_free;

endmodule

// ===== rtl/ltsolve_ctrl.sv =====
// controller: size register, item classification and sequencing of the
// datapath; uses ltsolve_pkg
`timescale 1ns / 1ps

module ltsolve_ctrl import ltsolve_pkg::*; #(
	parameter int MAX_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IDX_W-1:0]  row,
	input  logic [IDX_W-1:0]  col,
	output ltsolve_cmd_t      cmd,
	input  ltsolve_stat_t     stat
);

	localparam int EW = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_NUM,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic              last_q;
	logic [EW-1:0]     size_ext;
	logic [EW-1:0]     eff_size;
	logic [EW-1:0]     row_ext;
	logic              row_ok;
	logic              accept;

	assign size_ext = EW'(size_q);
	assign row_ext  = EW'(row);

	always_comb begin
		if (size_q == '0) begin
			eff_size = EW'(1);
		end else if (size_ext > EW'(MAX_SIZE)) begin
			eff_size = EW'(MAX_SIZE);
		end else begin
			eff_size = size_ext;
		end
	end

	assign row_ok    = (row_ext < eff_size);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_W'(CFG_RESET);
			last_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && row_ok) begin
						last_q <= (row_ext == eff_size - EW'(1));
						if (col < row) begin
							state_q <= ST_MUL;
						end else if (col == row) begin
							state_q <= ST_NUM;
						end
					end
				end
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_IDLE;
				ST_NUM:  state_q <= stat.coef_zero ? ST_FIN : ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.acc_en    = (state_q == ST_ACC);
		cmd.num_en    = (state_q == ST_NUM);
		cmd.div_start = (state_q == ST_LOAD);
		cmd.fin_en    = (state_q == ST_FIN) && stat.out_free;
		cmd.last      = last_q;
	end

endmodule

// ===== rtl/lower_triangular_solver.sv =====
// top level of the lower triangular solver, forward substitution in Q16.16
// depends on ltsolve_pkg, ltsolve_ctrl, ltsolve_dp
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata: row, col, coef, rhs
// m_*       out  m_tvalid/m_tready    tdata: index, value; tuser: flags; tlast
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: system size
//
// an off-diagonal item passes through ram read, multiply and saturating accumulate
// a diagonal item passes through numerator, divider load, the divider (one
// quotient bit per cycle) and result write; a zero pivot skips the divider
// items above the diagonal or outside the system are accepted and discarded
// a solved item waits in the output register, so a stalled m_tready only holds
// the block once the next diagonal result is ready; arst_n clears all control
`timescale 1ns / 1ps

module lower_triangular_solver import ltsolve_pkg::*; #(
	parameter int MAX_SIZE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // row_index, col_index, coef_value, rhs_value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // solution_index, solution_value, zero pad
	output logic [M_TUSER_W-1:0] m_tuser,   // zero_pivot, overflow_flag
	output logic                 m_tlast
);

	ltsolve_cmd_t  cmd;
	ltsolve_stat_t stat;

	ltsolve_ctrl #(
		.MAX_SIZE (MAX_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.row       (s_tdata[3:0]),
		.col       (s_tdata[7:4]),
		.cmd       (cmd),
		.stat      (stat)
	);

	ltsolve_dp #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
